// ===== hw/rtl/tgds_pkg.sv =====
// ----------------------------------------------------------------------------
// tgds_pkg
// Shared types and constants for the toroidal grid diffusion block.
// ----------------------------------------------------------------------------
package tgds_pkg;

   localparam int GRID_WIDTH  = 256;
   localparam int GRID_HEIGHT = 256;
   localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT;

   localparam int CELL_ADDR_W = $clog2(CELLS);
   localparam int COL_W       = $clog2(GRID_WIDTH);
   localparam int ROW_W       = $clog2(GRID_HEIGHT);
   localparam int COL_SEQ_W   = $clog2(GRID_WIDTH + 2);
   localparam int ROW_SEQ_W   = $clog2(GRID_HEIGHT + 2);

   localparam int OPCODE_W    = 2;
   localparam int COORD_W     = 8;
   localparam int VALUE_W     = 16;
   localparam int COLSUM_W    = VALUE_W + 2;
   localparam int ACC_W       = VALUE_W + 4;

   localparam logic [VALUE_W-1:0] ONE_FIXED = VALUE_W'(32768);

   typedef enum logic [OPCODE_W-1:0] {
      OP_WRITE = 2'd0,
      OP_STEP  = 2'd1,
      OP_READ  = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_STEP,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic clear_en;
      logic scan_start;
      logic scan_en;
      logic flip;
      logic req_write;
      logic req_read;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic scan_last;
      logic pipe_busy;
   } status_type;

endpackage

// ===== hw/rtl/tgds_ctrl.sv =====
// ----------------------------------------------------------------------------
// tgds_ctrl
// Controller: clearing pass, transaction decode and diffusion step sequencing.
// ----------------------------------------------------------------------------
module tgds_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [tgds_pkg::OPCODE_W-1:0]       req_opcode,
   input  tgds_pkg::status_type                status,
   output tgds_pkg::cmd_type                   cmd,
   output logic                                busy
);

   tgds_pkg::state_type state_ff;
   tgds_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tgds_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         tgds_pkg::ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_done) begin
               state_in = tgds_pkg::ST_IDLE;
            end
         end
         tgds_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               case (req_opcode)
                  tgds_pkg::OP_WRITE: cmd.req_write = 1'b1;
                  tgds_pkg::OP_READ:  cmd.req_read  = 1'b1;
                  tgds_pkg::OP_STEP: begin
                     cmd.scan_start = 1'b1;
                     state_in       = tgds_pkg::ST_STEP;
                  end
                  default: ;
               endcase
            end
         end
         tgds_pkg::ST_STEP: begin
            cmd.scan_en = 1'b1;
            if (status.scan_last) begin
               state_in = tgds_pkg::ST_DRAIN;
            end
         end
         tgds_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) begin
               cmd.flip = 1'b1;
               state_in = tgds_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tgds_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/tgds_datapath.sv =====
// ----------------------------------------------------------------------------
// tgds_datapath
// Two grid banks, raster scan with line buffers and a 3x3 window, and the
// stencil adder writing the new grid into the idle bank.
// ----------------------------------------------------------------------------
module tgds_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  tgds_pkg::cmd_type                   cmd,
   output tgds_pkg::status_type                status,
   input  logic [tgds_pkg::COORD_W-1:0]        req_cell_x,
   input  logic [tgds_pkg::COORD_W-1:0]        req_cell_y,
   input  logic [tgds_pkg::VALUE_W-1:0]        req_cell_value,
   output logic                                rsp_valid,
   output logic [tgds_pkg::VALUE_W-1:0]        rsp_read_value
);

   localparam int AW  = tgds_pkg::CELL_ADDR_W;
   localparam int VW  = tgds_pkg::VALUE_W;
   localparam int CW  = tgds_pkg::COL_W;
   localparam int RW  = tgds_pkg::ROW_W;
   localparam int CSW = tgds_pkg::COL_SEQ_W;
   localparam int RSW = tgds_pkg::ROW_SEQ_W;
   localparam int SW  = tgds_pkg::COLSUM_W;
   localparam int XW  = tgds_pkg::ACC_W;

   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                                input logic [CW-1:0] col);
      return AW'(AW'(row) * AW'(tgds_pkg::GRID_WIDTH) + AW'(col));
   endfunction

   // grid banks and line buffers
   logic [VW-1:0] bank0 [tgds_pkg::CELLS];
   logic [VW-1:0] bank1 [tgds_pkg::CELLS];
   logic [VW-1:0] lb1   [tgds_pkg::GRID_WIDTH];
   logic [VW-1:0] lb2   [tgds_pkg::GRID_WIDTH];

   logic           cur_ff;
   logic [AW-1:0]  clr_addr_ff;
   logic [CSW-1:0] col_ff;
   logic [RSW-1:0] row_ff;

   logic [VW-1:0]  rd0_ff, rd1_ff;
   logic [VW-1:0]  lb1_rd_ff, lb2_rd_ff;
   logic           s1_valid_ff;
   logic [CSW-1:0] s1_col_ff;
   logic [RSW-1:0] s1_row_ff;
   logic [CW-1:0]  s1_lbcol_ff;

   logic [SW-1:0]  sv_colsum_ff;
   logic [VW-1:0]  sv_mid_ff;

   logic [SW-1:0]  cs0_ff, cs1_ff, cs2_ff;
   logic [VW-1:0]  mid_new_ff, mid_ctr_ff;
   logic           s2_we_ff;
   logic [AW-1:0]  s2_addr_ff;

   logic           rsp_pending_ff;
   logic           rsp_inside_ff;

   // request decode
   logic           req_inside;
   logic [AW-1:0]  req_addr;
   logic [VW-1:0]  req_value_sat;

   assign req_inside    = (int'(req_cell_x) < tgds_pkg::GRID_WIDTH) &&
                          (int'(req_cell_y) < tgds_pkg::GRID_HEIGHT);
   assign req_addr      = cell_addr(RW'(req_cell_y), CW'(req_cell_x));
   assign req_value_sat = (req_cell_value > tgds_pkg::ONE_FIXED) ?
                          tgds_pkg::ONE_FIXED : req_cell_value;

   // scan position with wrap-around columns and rows
   logic [CW-1:0]  scan_col;
   logic [RW-1:0]  scan_row;
   logic [AW-1:0]  scan_addr;

   always_comb begin
      if (col_ff == '0) begin
         scan_col = CW'(tgds_pkg::GRID_WIDTH - 1);
      end else if (col_ff == CSW'(tgds_pkg::GRID_WIDTH + 1)) begin
         scan_col = '0;
      end else begin
         scan_col = CW'(col_ff - CSW'(1));
      end
      if (row_ff == '0) begin
         scan_row = RW'(tgds_pkg::GRID_HEIGHT - 1);
      end else if (row_ff == RSW'(tgds_pkg::GRID_HEIGHT + 1)) begin
         scan_row = '0;
      end else begin
         scan_row = RW'(row_ff - RSW'(1));
      end
   end

   assign scan_addr = cell_addr(scan_row, scan_col);

   logic [AW-1:0] rd_addr;
   assign rd_addr = cmd.scan_en ? scan_addr : req_addr;

   // stage 1 column triple
   logic [VW-1:0] grid_rd;
   logic [SW-1:0] colsum;
   logic [VW-1:0] mid_val;
   logic          s1_wrap;
   logic          lb_we;

   assign grid_rd = cur_ff ? rd1_ff : rd0_ff;
   assign s1_wrap = (s1_col_ff == CSW'(tgds_pkg::GRID_WIDTH + 1));
   assign lb_we   = s1_valid_ff && (s1_col_ff inside {[1:tgds_pkg::GRID_WIDTH]});
   assign colsum  = s1_wrap ? sv_colsum_ff :
                    SW'(SW'(lb2_rd_ff) + SW'(lb1_rd_ff) + SW'(grid_rd));
   assign mid_val = s1_wrap ? sv_mid_ff : lb1_rd_ff;

   // stage 2 stencil result
   logic [XW-1:0] acc;
   logic [VW-1:0] new_val;

   assign acc     = XW'({mid_ctr_ff, 3'b000}) - XW'(mid_ctr_ff) +
                    XW'(cs0_ff) + XW'(cs1_ff) + XW'(cs2_ff);
   assign new_val = acc[XW-1:4];

   // bank write ports
   logic          we0, we1;
   logic [AW-1:0] wa0, wa1;
   logic [VW-1:0] wd0, wd1;

   always_comb begin
      we0 = 1'b0;
      wa0 = req_addr;
      wd0 = req_value_sat;
      we1 = 1'b0;
      wa1 = req_addr;
      wd1 = req_value_sat;
      if (cmd.clear_en) begin
         we0 = 1'b1;
         wa0 = clr_addr_ff;
         wd0 = '0;
      end else if (cmd.req_write && req_inside) begin
         we0 = !cur_ff;
         we1 = cur_ff;
      end else if (s2_we_ff) begin
         we0 = cur_ff;
         we1 = !cur_ff;
         wa0 = s2_addr_ff;
         wa1 = s2_addr_ff;
         wd0 = new_val;
         wd1 = new_val;
      end
   end

   always_ff @(posedge clock) begin
      if (we0) begin
         bank0[wa0] <= wd0;
      end
      if (we1) begin
         bank1[wa1] <= wd1;
      end
      rd0_ff <= bank0[rd_addr];
      rd1_ff <= bank1[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (lb_we) begin
         lb1[s1_lbcol_ff] <= grid_rd;
         lb2[s1_lbcol_ff] <= lb1_rd_ff;
      end
      lb1_rd_ff <= lb1[scan_col];
      lb2_rd_ff <= lb2[scan_col];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff         <= 1'b0;
         clr_addr_ff    <= '0;
         col_ff         <= '0;
         row_ff         <= '0;
         s1_valid_ff    <= 1'b0;
         s2_we_ff       <= 1'b0;
         rsp_pending_ff <= 1'b0;
      end else begin
         if (cmd.flip) begin
            cur_ff <= !cur_ff;
         end
         if (cmd.clear_en) begin
            clr_addr_ff <= AW'(clr_addr_ff + AW'(1));
         end
         if (cmd.scan_start) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (cmd.scan_en) begin
            if (col_ff == CSW'(tgds_pkg::GRID_WIDTH + 1)) begin
               col_ff <= '0;
               row_ff <= RSW'(row_ff + RSW'(1));
            end else begin
               col_ff <= CSW'(col_ff + CSW'(1));
            end
         end
         s1_valid_ff    <= cmd.scan_en;
         s2_we_ff       <= s1_valid_ff &&
                           (s1_col_ff inside {[2:tgds_pkg::GRID_WIDTH + 1]}) &&
                           (s1_row_ff inside {[2:tgds_pkg::GRID_HEIGHT + 1]});
         rsp_pending_ff <= cmd.req_read;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_col_ff     <= col_ff;
      s1_row_ff     <= row_ff;
      s1_lbcol_ff   <= scan_col;
      rsp_inside_ff <= req_inside;
      if (s1_valid_ff && s1_col_ff == CSW'(1)) begin
         sv_colsum_ff <= colsum;
         sv_mid_ff    <= mid_val;
      end
      if (s1_valid_ff) begin
         cs0_ff     <= cs1_ff;
         cs1_ff     <= cs2_ff;
         cs2_ff     <= colsum;
         mid_ctr_ff <= mid_new_ff;
         mid_new_ff <= mid_val;
         s2_addr_ff <= cell_addr(RW'(s1_row_ff - RSW'(2)), CW'(s1_col_ff - CSW'(2)));
      end
   end

   assign status.clear_done = (clr_addr_ff == AW'(tgds_pkg::CELLS - 1));
   assign status.scan_last  = (col_ff == CSW'(tgds_pkg::GRID_WIDTH + 1)) &&
                              (row_ff == RSW'(tgds_pkg::GRID_HEIGHT + 1));
   assign status.pipe_busy  = s1_valid_ff || s2_we_ff;

   assign rsp_valid      = rsp_pending_ff;
   assign rsp_read_value = rsp_inside_ff ? grid_rd : '0;

endmodule

// ===== hw/rtl/toroidal_grid_diffusion_step_top.sv =====
// ----------------------------------------------------------------------------
// toroidal_grid_diffusion_step_top
// Grid of fixed point cells with write, read and eight-neighbor diffusion step.
// ----------------------------------------------------------------------------
// write: one cycle; read: result strobed in the cycle after the transaction
// step: busy for (GRID_WIDTH+2)*(GRID_HEIGHT+2)+3 cycles, set by the single
//   grid read port scanning one cell per cycle with wrap-around reads
// reset: busy for GRID_WIDTH*GRID_HEIGHT cycles while the grid is cleared
// results cannot be stalled by the receiver
module toroidal_grid_diffusion_step_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [tgds_pkg::OPCODE_W-1:0]       req_opcode,
   input  logic [tgds_pkg::COORD_W-1:0]        req_cell_x,
   input  logic [tgds_pkg::COORD_W-1:0]        req_cell_y,
   input  logic [tgds_pkg::VALUE_W-1:0]        req_cell_value,
   output logic                                rsp_valid,
   output logic [tgds_pkg::VALUE_W-1:0]        rsp_read_value
);

   tgds_pkg::cmd_type    cmd;
   tgds_pkg::status_type status;

   tgds_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy)
   );

   tgds_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_cell_x     (req_cell_x),
      .req_cell_y     (req_cell_y),
      .req_cell_value (req_cell_value),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value)
   );

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the toroidal grid diffusion block.
// Directed transactions hit the clamp and wrap-around corners first. Random
// rounds then seed a small window of cells, run a diffusion step and read
// the window back, with ignored opcodes and stray reads and writes mixed in.
// A scoreboard keeps its own copy of the grid, applies each accepted
// transaction and checks every strobed read value in order.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CLK_PERIOD     = 8;
   localparam int RESET_CYCLES   = 11;
   localparam int STEP_CYCLES    = (tgds_pkg::GRID_WIDTH + 2) *
                                   (tgds_pkg::GRID_HEIGHT + 2) + 3;
   localparam int TIMEOUT_CYCLES = 4000000;
   localparam int RANDOM_ROUNDS  = 5;
   localparam int MAX_GAP        = 14;

   localparam logic [tgds_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

   typedef enum int {
      CHK_OK,
      CHK_UNEXPECTED,
      CHK_MISMATCH
   } check_status_type;

   class diffusion_scoreboard;
      bit [tgds_pkg::VALUE_W-1:0]   cells      [tgds_pkg::CELLS];
      bit [tgds_pkg::VALUE_W-1:0]   next_cells [tgds_pkg::CELLS];
      logic [tgds_pkg::VALUE_W-1:0] pending_read_values [$];

      function int unsigned value_at(int unsigned x, int unsigned y);
         return 32'(cells[y * tgds_pkg::GRID_WIDTH + x]);
      endfunction

      function void diffuse_grid();
         int unsigned x, y, xl, xr, yu, yd, sum;
         for (y = 0; y < tgds_pkg::GRID_HEIGHT; y++) begin
            yu = (y == 0) ? tgds_pkg::GRID_HEIGHT - 1 : y - 1;
            yd = (y + 1 == tgds_pkg::GRID_HEIGHT) ? 0 : y + 1;
            for (x = 0; x < tgds_pkg::GRID_WIDTH; x++) begin
               xl = (x == 0) ? tgds_pkg::GRID_WIDTH - 1 : x - 1;
               xr = (x + 1 == tgds_pkg::GRID_WIDTH) ? 0 : x + 1;
               sum = value_at(x, yu) + value_at(x, yd)
                   + value_at(xl, y) + value_at(xr, y)
                   + value_at(xl, yu) + value_at(xr, yu)
                   + value_at(xl, yd) + value_at(xr, yd);
               sum = ((value_at(x, y) << 3) + sum) >> 4;
               if (sum > 32'hFFFF)
                  sum = 32'hFFFF;
               next_cells[y * tgds_pkg::GRID_WIDTH + x] = tgds_pkg::VALUE_W'(sum);
            end
         end
         cells = next_cells;
      endfunction

      function void note_transaction(logic [tgds_pkg::OPCODE_W-1:0] op,
                                     logic [tgds_pkg::COORD_W-1:0] x,
                                     logic [tgds_pkg::COORD_W-1:0] y,
                                     logic [tgds_pkg::VALUE_W-1:0] v);
         bit in_grid;
         in_grid = (int'(x) < tgds_pkg::GRID_WIDTH) && (int'(y) < tgds_pkg::GRID_HEIGHT);
         case (op)
            tgds_pkg::OP_WRITE: begin
               if (in_grid)
                  cells[int'(y) * tgds_pkg::GRID_WIDTH + int'(x)] =
                     (v > tgds_pkg::ONE_FIXED) ? tgds_pkg::ONE_FIXED : v;
            end
            tgds_pkg::OP_STEP: diffuse_grid();
            tgds_pkg::OP_READ: begin
               if (in_grid)
                  pending_read_values.push_back(
                     cells[int'(y) * tgds_pkg::GRID_WIDTH + int'(x)]);
               else
                  pending_read_values.push_back('0);
            end
            default: ;
         endcase
      endfunction

      function check_status_type check_read_result(
         logic [tgds_pkg::VALUE_W-1:0] got,
         output logic [tgds_pkg::VALUE_W-1:0] want);
         want = '0;
         if (pending_read_values.size() == 0)
            return CHK_UNEXPECTED;
         want = pending_read_values.pop_front();
         return (got === want) ? CHK_OK : CHK_MISMATCH;
      endfunction

      function int pending();
         return pending_read_values.size();
      endfunction
   endclass

   logic                          clock          = 1'b0;
   logic                          reset          = 1'b1;
   logic                          start          = 1'b0;
   logic                          busy;
   logic [tgds_pkg::OPCODE_W-1:0] req_opcode     = '0;
   logic [tgds_pkg::COORD_W-1:0]  req_cell_x     = '0;
   logic [tgds_pkg::COORD_W-1:0]  req_cell_y     = '0;
   logic [tgds_pkg::VALUE_W-1:0]  req_cell_value = '0;
   logic                          rsp_valid;
   logic [tgds_pkg::VALUE_W-1:0]  rsp_read_value;

   diffusion_scoreboard           sb = new();
   int                            error_count = 0;
   bit                            no_idle     = 1'b0;
   logic [tgds_pkg::VALUE_W-1:0]  expected_read;

   toroidal_grid_diffusion_step_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_cell_x     (req_cell_x),
      .req_cell_y     (req_cell_y),
      .req_cell_value (req_cell_value),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(CLK_PERIOD * TIMEOUT_CYCLES);
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic report_mismatch(string msg);
      $display("mismatch: %s", msg);
      error_count++;
   endtask

   task automatic send_item(logic [tgds_pkg::OPCODE_W-1:0] op,
                            logic [tgds_pkg::COORD_W-1:0] x,
                            logic [tgds_pkg::COORD_W-1:0] y,
                            logic [tgds_pkg::VALUE_W-1:0] v);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_opcode     <= op;
      req_cell_x     <= x;
      req_cell_y     <= y;
      req_cell_value <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_transaction(op, x, y, v);
   endtask

   task automatic wait_for_reads();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // random window value, now and then a raw 16-bit word to hit the clamp
   function automatic logic [tgds_pkg::VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 4) == 0)
         return tgds_pkg::VALUE_W'($urandom);
      return tgds_pkg::VALUE_W'($urandom_range(0, 32768));
   endfunction

   task automatic send_noise();
      case ($urandom_range(0, 2))
         0: send_item(OP_UNUSED, tgds_pkg::COORD_W'($urandom),
                      tgds_pkg::COORD_W'($urandom), tgds_pkg::VALUE_W'($urandom));
         1: send_item(tgds_pkg::OP_READ, tgds_pkg::COORD_W'($urandom),
                      tgds_pkg::COORD_W'($urandom), tgds_pkg::VALUE_W'($urandom));
         default: send_item(tgds_pkg::OP_WRITE, tgds_pkg::COORD_W'($urandom),
                            tgds_pkg::COORD_W'($urandom), tgds_pkg::VALUE_W'($urandom));
      endcase
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         case (sb.check_read_result(rsp_read_value, expected_read))
            CHK_UNEXPECTED:
               report_mismatch($sformatf("read value %0d with no read pending",
                                         rsp_read_value));
            CHK_MISMATCH:
               report_mismatch($sformatf("read value %0d, expected %0d",
                                         rsp_read_value, expected_read));
            default: ;
         endcase
      end
   end

   initial begin
      logic [tgds_pkg::COORD_W-1:0] base_x, base_y;
      int                           count, drain;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // cleared grid, clamp on write, ignored opcode, wrap-around corners
      send_item(tgds_pkg::OP_READ,  8'd0,   8'd0,   16'h0000);
      send_item(tgds_pkg::OP_READ,  8'd255, 8'd255, 16'hFFFF);
      send_item(tgds_pkg::OP_WRITE, 8'd0,   8'd0,   16'd32768);
      send_item(tgds_pkg::OP_WRITE, 8'd255, 8'd255, 16'hFFFF);
      send_item(tgds_pkg::OP_WRITE, 8'd255, 8'd0,   16'd32769);
      send_item(tgds_pkg::OP_WRITE, 8'd0,   8'd255, 16'h0000);
      send_item(tgds_pkg::OP_WRITE, 8'd128, 8'd64,  16'd1);
      send_item(tgds_pkg::OP_WRITE, 8'd17,  8'd200, 16'h7FFF);
      send_item(tgds_pkg::OP_READ,  8'd0,   8'd0,   16'h0000);
      send_item(tgds_pkg::OP_READ,  8'd255, 8'd255, 16'h0000);
      send_item(tgds_pkg::OP_READ,  8'd255, 8'd0,   16'h0000);
      send_item(tgds_pkg::OP_READ,  8'd128, 8'd64,  16'h0000);
      send_item(OP_UNUSED,          8'd0,   8'd0,   16'hFFFF);
      send_item(tgds_pkg::OP_READ,  8'd0,   8'd0,   16'h0000);
      send_item(tgds_pkg::OP_STEP,  8'd0,   8'd0,   16'h0000);
      send_item(tgds_pkg::OP_READ,  8'd0,   8'd0,   16'h0000);
      send_item(tgds_pkg::OP_READ,  8'd1,   8'd1,   16'h0000);
      send_item(tgds_pkg::OP_READ,  8'd254, 8'd254, 16'h0000);
      send_item(tgds_pkg::OP_READ,  8'd0,   8'd255, 16'h0000);
      send_item(tgds_pkg::OP_READ,  8'd255, 8'd0,   16'h0000);
      send_item(tgds_pkg::OP_READ,  8'd128, 8'd64,  16'h0000);
      send_item(tgds_pkg::OP_READ,  8'd129, 8'd65,  16'h0000);
      send_item(tgds_pkg::OP_STEP,  8'd255, 8'd255, 16'hFFFF);
      send_item(tgds_pkg::OP_READ,  8'd0,   8'd0,   16'h0000);
      send_item(tgds_pkg::OP_READ,  8'd1,   8'd0,   16'h0000);

      // seed a window, diffuse, read the window back
      for (int round = 0; round < RANDOM_ROUNDS; round++) begin
         no_idle = ($urandom_range(0, 2) == 0);
         case ($urandom_range(0, 3))
            0:       base_x = 8'd0;
            1:       base_x = 8'd254;
            default: base_x = tgds_pkg::COORD_W'($urandom);
         endcase
         case ($urandom_range(0, 3))
            0:       base_y = 8'd255;
            1:       base_y = 8'd0;
            default: base_y = tgds_pkg::COORD_W'($urandom);
         endcase
         count = $urandom_range(3, 8);
         repeat (count)
            send_item(tgds_pkg::OP_WRITE,
                      tgds_pkg::COORD_W'(base_x + $urandom_range(0, 3)),
                      tgds_pkg::COORD_W'(base_y + $urandom_range(0, 3)), pick_value());
         repeat ($urandom_range(1, 2)) send_noise();
         send_item(tgds_pkg::OP_STEP, tgds_pkg::COORD_W'($urandom),
                   tgds_pkg::COORD_W'($urandom), tgds_pkg::VALUE_W'($urandom));
         count = $urandom_range(4, 8);
         repeat (count)
            send_item(tgds_pkg::OP_READ,
                      tgds_pkg::COORD_W'(base_x + $urandom_range(0, 5) - 1),
                      tgds_pkg::COORD_W'(base_y + $urandom_range(0, 5) - 1),
                      tgds_pkg::VALUE_W'($urandom));
         if (round == RANDOM_ROUNDS / 2)
            wait_for_reads();
      end

      start <= 1'b0;
      drain = 0;
      while (sb.pending() != 0 && drain < STEP_CYCLES) begin
         @(posedge clock);
         drain++;
      end
      repeat (STEP_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         report_mismatch($sformatf("%0d reads never answered", sb.pending()));

      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
